// ===== src/ecal_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ecal_pkg;

  // Micro-operations that one control word can ask of the datapath.
  typedef enum logic [3:0] {
    OP_LOAD,
    OP_MUL,
    OP_FIX,
    OP_WDSET,
    OP_YINIT,
    OP_YSTEP,
    OP_MSTEP,
    OP_DONE,
    OP_NOP
  } op_t;

  // Divisor select: also picks the field that receives the remainder.
  typedef enum logic [1:0] {
    DV_SEC,
    DV_MIN,
    DV_HR,
    DV_WD
  } dv_t;

  // Jump conditions. When the condition holds the sequencer goes to the
  // target step, otherwise it moves on to the next step.
  typedef enum logic [2:0] {
    J_NEVER,
    J_NOIN,
    J_YMORE,
    J_MMORE,
    J_OBUSY,
    J_ALWAYS
  } jc_t;

  localparam int StepW = 4;

  // Step addresses of the microprogram.
  localparam logic [StepW-1:0] STEP_LOAD   = 4'd0;
  localparam logic [StepW-1:0] STEP_SEC_M  = 4'd1;
  localparam logic [StepW-1:0] STEP_SEC_F  = 4'd2;
  localparam logic [StepW-1:0] STEP_MIN_M  = 4'd3;
  localparam logic [StepW-1:0] STEP_MIN_F  = 4'd4;
  localparam logic [StepW-1:0] STEP_HR_M   = 4'd5;
  localparam logic [StepW-1:0] STEP_HR_F   = 4'd6;
  localparam logic [StepW-1:0] STEP_WDSET  = 4'd7;
  localparam logic [StepW-1:0] STEP_WD_M   = 4'd8;
  localparam logic [StepW-1:0] STEP_WD_F   = 4'd9;
  localparam logic [StepW-1:0] STEP_YINIT  = 4'd10;
  localparam logic [StepW-1:0] STEP_YEAR   = 4'd11;
  localparam logic [StepW-1:0] STEP_MONTH  = 4'd12;
  localparam logic [StepW-1:0] STEP_DONE   = 4'd13;
  localparam logic [StepW-1:0] STEP_WRAP   = 4'd14;

  // Calendar constants.
  localparam logic [11:0] EPOCH_YEAR   = 12'd1970;
  localparam logic [6:0]  EPOCH_MOD100 = 7'd70;
  localparam logic [8:0]  EPOCH_MOD400 = 9'd370;
  localparam logic [8:0]  DAYS_COMMON  = 9'd365;
  localparam logic [8:0]  DAYS_LEAP    = 9'd366;
  localparam logic [3:0]  LAST_MONTH   = 4'd11;
  localparam logic [15:0] WD_OFFSET    = 16'd3;

  typedef struct packed {
    op_t              op;
    dv_t              dv;
    jc_t              jc;
    logic [StepW-1:0] target;
  } ctrl_t;

  // Conditions the sequencer branches on.
  typedef struct packed {
    logic in_fire;
    logic obusy;
    logic ymore;
    logic mmore;
  } stat_t;

  // Finished fields of one result.
  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  mon;
    logic [11:0] year;
    logic [2:0]  wd;
    logic [4:0]  hr;
    logic [5:0]  min;
    logic [5:0]  sec;
  } res_t;

  // Microprogram store.
  function automatic ctrl_t rom(input logic [StepW-1:0] step);
    ctrl_t w;
    w = '{op: OP_NOP, dv: DV_SEC, jc: J_NEVER, target: STEP_LOAD};
    unique case (step)
      STEP_LOAD:  w = '{op: OP_LOAD,  dv: DV_SEC, jc: J_NOIN,   target: STEP_LOAD};
      STEP_SEC_M: w = '{op: OP_MUL,   dv: DV_SEC, jc: J_NEVER,  target: STEP_LOAD};
      STEP_SEC_F: w = '{op: OP_FIX,   dv: DV_SEC, jc: J_NEVER,  target: STEP_LOAD};
      STEP_MIN_M: w = '{op: OP_MUL,   dv: DV_MIN, jc: J_NEVER,  target: STEP_LOAD};
      STEP_MIN_F: w = '{op: OP_FIX,   dv: DV_MIN, jc: J_NEVER,  target: STEP_LOAD};
      STEP_HR_M:  w = '{op: OP_MUL,   dv: DV_HR,  jc: J_NEVER,  target: STEP_LOAD};
      STEP_HR_F:  w = '{op: OP_FIX,   dv: DV_HR,  jc: J_NEVER,  target: STEP_LOAD};
      STEP_WDSET: w = '{op: OP_WDSET, dv: DV_WD,  jc: J_NEVER,  target: STEP_LOAD};
      STEP_WD_M:  w = '{op: OP_MUL,   dv: DV_WD,  jc: J_NEVER,  target: STEP_LOAD};
      STEP_WD_F:  w = '{op: OP_FIX,   dv: DV_WD,  jc: J_NEVER,  target: STEP_LOAD};
      STEP_YINIT: w = '{op: OP_YINIT, dv: DV_SEC, jc: J_NEVER,  target: STEP_LOAD};
      STEP_YEAR:  w = '{op: OP_YSTEP, dv: DV_SEC, jc: J_YMORE,  target: STEP_YEAR};
      STEP_MONTH: w = '{op: OP_MSTEP, dv: DV_SEC, jc: J_MMORE,  target: STEP_MONTH};
      STEP_DONE:  w = '{op: OP_DONE,  dv: DV_SEC, jc: J_OBUSY,  target: STEP_DONE};
      STEP_WRAP:  w = '{op: OP_NOP,   dv: DV_SEC, jc: J_ALWAYS, target: STEP_LOAD};
      default:    w = '{op: OP_NOP,   dv: DV_SEC, jc: J_ALWAYS, target: STEP_LOAD};
    endcase
    return w;
  endfunction

  // Divisor for each division step.
  function automatic logic [5:0] div_const(input dv_t dv);
    logic [5:0] d;
    d = 6'd60;
    unique case (dv)
      DV_SEC: d = 6'd60;
      DV_MIN: d = 6'd60;
      DV_HR:  d = 6'd24;
      DV_WD:  d = 6'd7;
    endcase
    return d;
  endfunction

  // Reciprocal floor(2^32 / divisor); the quotient estimate is then exact
  // or one short, which the fix-up step corrects.
  function automatic logic [31:0] div_recip(input dv_t dv);
    logic [31:0] r;
    r = 32'd71582788;
    unique case (dv)
      DV_SEC: r = 32'd71582788;
      DV_MIN: r = 32'd71582788;
      DV_HR:  r = 32'd178956970;
      DV_WD:  r = 32'd613566756;
    endcase
    return r;
  endfunction

  // Length of a month, index 0 for January.
  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] n;
    n = 5'd31;
    unique case (mon)
      4'd1:    n = leap ? 5'd29 : 5'd28;
      4'd3:    n = 5'd30;
      4'd5:    n = 5'd30;
      4'd8:    n = 5'd30;
      4'd10:   n = 5'd30;
      default: n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== src/ecal_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ecal_seq (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire ecal_pkg::stat_t stat,
  output ecal_pkg::ctrl_t     ctrl
);

  logic [ecal_pkg::StepW-1:0] step;
  logic [ecal_pkg::StepW-1:0] step_next;
  logic                       taken;

  // Current control word straight from the program store.
  assign ctrl = ecal_pkg::rom(step);

  // Evaluate the jump condition of the current word.
  always_comb begin
    unique case (ctrl.jc)
      ecal_pkg::J_NEVER:  taken = 1'b0;
      ecal_pkg::J_NOIN:   taken = !stat.in_fire;
      ecal_pkg::J_YMORE:  taken = stat.ymore;
      ecal_pkg::J_MMORE:  taken = stat.mmore;
      ecal_pkg::J_OBUSY:  taken = stat.obusy;
      ecal_pkg::J_ALWAYS: taken = 1'b1;
      default:            taken = 1'b1;
    endcase
    step_next = taken ? ctrl.target : step + 1'b1;
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ecal_pkg::STEP_LOAD;
    end else begin
      step <= step_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/ecal_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ecal_dp (
  input  wire logic            clk,
  input  wire ecal_pkg::ctrl_t ctrl,
  input  wire logic [31:0]     epoch_seconds,
  output logic                 ymore,
  output logic                 mmore,
  output ecal_pkg::res_t       res
);

  // Working registers.
  logic [31:0] num;
  logic [31:0] q0;
  logic [15:0] days;
  logic [11:0] year;
  logic [6:0]  y100;
  logic [8:0]  y400;
  logic [3:0]  mon;
  logic [5:0]  sec;
  logic [5:0]  min;
  logic [4:0]  hr;
  logic [2:0]  wd;

  logic [63:0] prod;
  logic [5:0]  dconst;
  logic [31:0] rem_raw;
  logic [6:0]  rem_lo;
  logic        rem_ge;
  logic [31:0] q_fin;
  logic [5:0]  rem_fin;
  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  mlen;

  // Reciprocal multiply and the one-step quotient correction.
  always_comb begin
    dconst  = ecal_pkg::div_const(ctrl.dv);
    prod    = {32'd0, num} * {32'd0, ecal_pkg::div_recip(ctrl.dv)};
    rem_raw = num - 32'(q0 * {26'd0, dconst});
    rem_lo  = rem_raw[6:0];
    rem_ge  = rem_lo >= {1'b0, dconst};
    q_fin   = q0 + {31'd0, rem_ge};
    rem_fin = rem_ge ? 6'(rem_lo - {1'b0, dconst}) : rem_lo[5:0];
  end

  // Gregorian leap rule from the running year residues.
  always_comb begin
    leap  = ((year[1:0] == 2'd0) && (y100 != 7'd0)) || (y400 == 9'd0);
    ylen  = leap ? ecal_pkg::DAYS_LEAP : ecal_pkg::DAYS_COMMON;
    ymore = days >= {7'd0, ylen};
    mlen  = ecal_pkg::month_len(mon, leap);
    mmore = (mon < ecal_pkg::LAST_MONTH) && (days >= {11'd0, mlen});
  end

  // Micro-operations.
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      ecal_pkg::OP_LOAD: begin
        num <= epoch_seconds;
      end
      ecal_pkg::OP_MUL: begin
        q0 <= prod[63:32];
      end
      ecal_pkg::OP_FIX: begin
        num <= q_fin;
        unique case (ctrl.dv)
          ecal_pkg::DV_SEC: sec <= rem_fin;
          ecal_pkg::DV_MIN: min <= rem_fin;
          ecal_pkg::DV_HR: begin
            hr   <= rem_fin[4:0];
            days <= q_fin[15:0];
          end
          ecal_pkg::DV_WD:  wd <= rem_fin[2:0] + 3'd1;
        endcase
      end
      ecal_pkg::OP_WDSET: begin
        num <= {16'd0, days + ecal_pkg::WD_OFFSET};
      end
      ecal_pkg::OP_YINIT: begin
        year <= ecal_pkg::EPOCH_YEAR;
        y100 <= ecal_pkg::EPOCH_MOD100;
        y400 <= ecal_pkg::EPOCH_MOD400;
        mon  <= 4'd0;
      end
      ecal_pkg::OP_YSTEP: begin
        if (ymore) begin
          days <= days - {7'd0, ylen};
          year <= year + 12'd1;
          y100 <= (y100 == 7'd99) ? 7'd0 : y100 + 7'd1;
          y400 <= (y400 == 9'd399) ? 9'd0 : y400 + 9'd1;
        end
      end
      ecal_pkg::OP_MSTEP: begin
        if (mmore) begin
          days <= days - {11'd0, mlen};
          mon  <= mon + 4'd1;
        end
      end
      ecal_pkg::OP_DONE: begin
      end
      ecal_pkg::OP_NOP: begin
      end
      default: begin
      end
    endcase
  end

  // Result fields.
  always_comb begin
    res.sec  = sec;
    res.min  = min;
    res.hr   = hr;
    res.wd   = wd;
    res.year = year;
    res.mon  = mon + 4'd1;
    res.day  = days[4:0] + 5'd1;
  end

endmodule

`default_nettype wire

// ===== src/epoch_seconds_to_calendar_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Converts a count of seconds since 1970-01-01 00:00:00 into the calendar
// date and time of that instant, one result beat for every input beat.
// Input channel s_*: tdata carries the 32-bit seconds count.
// Output channel m_*: tdata carries second, minute, hour, weekday (Monday
// is 1), full year, month and day of month.
// A small microprogram drives a shared datapath: three reciprocal
// divisions take two steps each, the weekday division two more, then the
// year loop steps one year at a time past 1970 and the month loop one
// month at a time past January.
// After the result is written into the output register the sequencer
// passes through the wrap step back to the load step, where the next
// input beat is taken; no new beat is taken while one is being worked
// on, so the year loop sets the rate.
// Reset returns the sequencer to the load step and drops m_tvalid.
// When the receiver stalls, the result holds in the output register while
// the next input beat is taken and worked on; that beat waits at its
// final step until the register is free.
module epoch_seconds_to_calendar_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // s_tdata: epoch_seconds[31:0]
  input  wire logic [31:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // m_tdata: second_of_minute[5:0], minute_of_hour[11:6], hour_of_day[16:12],
  // weekday[19:17], full_year[31:20], month_number[35:32],
  // day_of_month[40:36], zeros[47:41]
  output logic [47:0]      m_tdata
);

  ecal_pkg::ctrl_t ctrl;
  ecal_pkg::stat_t stat;
  ecal_pkg::res_t  res;
  logic            ymore;
  logic            mmore;
  logic            obusy;
  logic            out_load;

  // Handshake and branch conditions.
  assign s_tready = (ctrl.op == ecal_pkg::OP_LOAD) && !rst;
  assign obusy    = m_tvalid && !m_tready;
  assign out_load = (ctrl.op == ecal_pkg::OP_DONE) && !obusy;

  always_comb begin
    stat.in_fire = s_tvalid && s_tready;
    stat.obusy   = obusy;
    stat.ymore   = ymore;
    stat.mmore   = mmore;
  end

  ecal_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  ecal_dp u_dp (
    .clk           (clk),
    .ctrl          (ctrl),
    .epoch_seconds (s_tdata),
    .ymore         (ymore),
    .mmore         (mmore),
    .res           (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {7'd0, res.day, res.mon, res.year, res.wd, res.hr, res.min, res.sec};
    end
  end

endmodule

`default_nettype wire

// ===== verif/epoch_seconds_to_calendar_unit_tb.sv =====
`timescale 1ns / 1ps

module epoch_seconds_to_calendar_unit_tb;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // s_tdata: epoch_seconds[31:0]
  logic [31:0] s_tdata = 32'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // m_tdata: second_of_minute[5:0], minute_of_hour[11:6], hour_of_day[16:12],
  // weekday[19:17], full_year[31:20], month_number[35:32],
  // day_of_month[40:36], zeros[47:41]
  logic [47:0] m_tdata;

  // Dates predicted for accepted input beats, oldest first.
  ecal_pkg::res_t pending_dates[$];
  int   error_count = 0;
  // Percent chance per cycle of a sender gap or a receiver stall.
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  // Length of a receiver hold-off asked for by a test; taken up by the monitor.
  int   hold_request = 0;

  epoch_seconds_to_calendar_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // Civil date and time of a seconds count, with the Gregorian leap rule.
  function automatic ecal_pkg::res_t civil_from_epoch(input logic [31:0] secs);
    int unsigned    days;
    int unsigned    year;
    int unsigned    month;
    int unsigned    len;
    bit             leap;
    ecal_pkg::res_t r;
    r.sec = 6'(secs % 60);
    days  = secs / 60;
    r.min = 6'(days % 60);
    days  = days / 60;
    r.hr  = 5'(days % 24);
    days  = days / 24;
    // Day zero was a Thursday, and Monday counts as 1.
    r.wd  = 3'((days + 3) % 7 + 1);
    year  = 1970;
    leap  = 1'b0;
    forever begin
      leap = ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
      len  = leap ? 366 : 365;
      if (days < len) break;
      days -= len;
      year++;
    end
    // Walk the months; December takes whatever is left.
    month = 0;
    while (month < 11) begin
      case (month)
        1:          len = leap ? 29 : 28;
        3, 5, 8, 10: len = 30;
        default:    len = 31;
      endcase
      if (days < len) break;
      days -= len;
      month++;
    end
    r.year = 12'(year);
    r.mon  = 4'(month + 1);
    r.day  = 5'(days + 1);
    return r;
  endfunction

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endtask

  // Offers one seconds count after a random gap and records its date once taken.
  task automatic send_seconds(input logic [31:0] secs);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= secs;
    do @(posedge clk); while (!s_tready);
    pending_dates.push_back(civil_from_epoch(secs));
  endtask

  // Stops offering beats until every pending date has come back.
  task automatic wait_for_dates;
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_dates.size() != 0);
  endtask

  // Random seconds counts: half fully random, a quarter at the first, last or
  // random second of a day, the rest around year ends and the end of February.
  task automatic run_random(input int count, input int idle, input int stall);
    logic [31:0] secs;
    int unsigned day;
    int unsigned tod;
    int unsigned year;
    int unsigned target;
    int unsigned offset;
    send_idle_pct = idle;
    stall_pct     = stall;
    repeat (count) begin
      case ($urandom_range(3))
        0, 1: secs = $urandom;
        2: begin
          day = $urandom_range(49709);
          case ($urandom_range(2))
            0:       tod = 0;
            1:       tod = 86399;
            default: tod = $urandom_range(86399);
          endcase
          secs = day * 86400 + tod;
        end
        default: begin
          target = $urandom_range(1970, 2105);
          day = 0;
          for (year = 1970; year < target; year++)
            day += (((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0)) ? 366 : 365;
          case ($urandom_range(5))
            0:       offset = 0;
            1:       offset = 58;
            2:       offset = 59;
            3:       offset = 60;
            4:       offset = 364;
            default: offset = 365;
          endcase
          secs = (day + offset) * 86400 + $urandom_range(86399);
        end
      endcase
      send_seconds(secs);
    end
  endtask

  // Field extremes, leap days, century years and the largest input.
  task automatic test_directed;
    logic [31:0] corner_secs [25];
    corner_secs = '{32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399,
                    32'd86400, 32'd31535999, 32'd31536000, 32'd68169600,
                    32'd951782399, 32'd951782400, 32'd951868800, 32'd978220800,
                    32'd4107542399, 32'd4107542400, 32'd4233686400,
                    32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
                    32'hFFFF_FFFD, 32'hFFFF_FFFE, 32'hFFFF_FFFF};
    send_idle_pct = 0;
    stall_pct     = 0;
    foreach (corner_secs[i]) send_seconds(corner_secs[i]);
    wait_for_dates;
  endtask

  // The receiver holds off while beats keep coming, so the input stalls.
  task automatic test_output_hold;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_request  = 700;
    repeat (6) send_seconds($urandom);
    wait_for_dates;
  endtask

  task automatic test_streaming;
    run_random(275, 0, 0);
    wait_for_dates;
  endtask

  task automatic test_sender_gaps;
    run_random(275, 58, 0);
    wait_for_dates;
  endtask

  task automatic test_receiver_stalls;
    run_random(275, 0, 58);
    wait_for_dates;
  endtask

  task automatic test_mixed_idling;
    run_random(275, 32, 32);
    wait_for_dates;
  endtask

  // Result monitor: checks each accepted beat and drives the ready line.
  initial begin : result_monitor
    ecal_pkg::res_t got;
    ecal_pkg::res_t want;
    int             hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got = m_tdata[40:0];
        if (pending_dates.size() == 0) begin
          $error("result beat with no date pending: m_tdata %h", m_tdata);
          error_count++;
        end else begin
          want = pending_dates.pop_front();
          compare_field("second_of_minute", int'(want.sec), int'(got.sec));
          compare_field("minute_of_hour", int'(want.min), int'(got.min));
          compare_field("hour_of_day", int'(want.hr), int'(got.hr));
          compare_field("weekday", int'(want.wd), int'(got.wd));
          compare_field("full_year", int'(want.year), int'(got.year));
          compare_field("month_number", int'(want.mon), int'(got.mon));
          compare_field("day_of_month", int'(want.day), int'(got.day));
          compare_field("zero padding", 0, int'(m_tdata[47:41]));
        end
      end
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed;
    test_output_hold;
    test_streaming;
    test_sender_gaps;
    test_receiver_stalls;
    test_mixed_idling;
    wait_for_dates;
    repeat (200) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
